// ===== rtl/core/perspective_inverse_point_map_macros.svh =====
// Assertion macros used by the perspective point map top level.
`ifndef PERSPECTIVE_INVERSE_POINT_MAP_MACROS_SVH
`define PERSPECTIVE_INVERSE_POINT_MAP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PIPM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("implication check failed");
// Next-cycle implication, disabled during reset.
`define PIPM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define PIPM_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define PIPM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/pipm_pkg.sv =====
// Widths, register indexes and constants of the perspective point map.
package pipm_pkg;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int COEF_W     = 32;
	localparam int FOCAL_W    = 28;
	localparam int OUT_W      = 32;
	localparam int Q_W        = 32;
	localparam int FOCAL_SH   = 22;
	localparam int SCALE_SH   = FRAC_BITS - 8;
	localparam int PROD_W     = COEF_W + COORD_BITS;
	localparam int P_W        = PROD_W + 1;
	localparam int FZ_W       = FOCAL_W + FOCAL_SH;
	localparam int Z_W        = ((P_W > FZ_W) ? P_W : FZ_W) + 2;
	localparam int D_W        = Z_W - 1;
	localparam int MAG_W      = P_W;
	localparam int H_W        = (MAG_W + 1) / 2;
	localparam int HI_W       = MAG_W - H_W;
	localparam int NUM_W      = MAG_W + FOCAL_W + SCALE_SH;
	localparam int TOP_W      = NUM_W - Q_W;
	localparam int CMP_W      = (TOP_W > D_W) ? TOP_W : D_W;
	localparam int LANE_LAT   = Q_W + 1;
	localparam int IDX_W      = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_COEF_XX = 3'd0,
		REG_COEF_XY = 3'd1,
		REG_COEF_YX = 3'd2,
		REG_COEF_YY = 3'd3,
		REG_COEF_ZX = 3'd4,
		REG_COEF_ZY = 3'd5,
		REG_FOCAL   = 3'd6
	} reg_idx_t;

	localparam logic [COEF_W-1:0]  COEF_ONE    = 32'h4000_0000;
	localparam logic [FOCAL_W-1:0] FOCAL_RESET = 28'd256;
	localparam logic [OUT_W-1:0]   SAT_POS     = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0]   SAT_NEG     = 32'h8000_0000;
endpackage

// ===== rtl/core/perspective_inverse_point_map.sv =====
// Top level of the perspective inverse point map.
// Maps one destination pixel (dest_x, dest_y, relative to the image centre) to the
// source point for interpolation under a tilt/shift perspective correction.
// Request channel: drive dest_x/dest_y with start high; the request is taken at any
// edge where busy is low, and busy is always low, so one request per cycle is taken.
// Result channel: done pulses for one cycle with src_x, src_y (Q16.16), behind_plane
// and saturated. Results leave in request order.
// Throughput is one point per cycle: five arithmetic stages (products, sums,
// magnitude, split focal multiply, numerator assembly), then a 33 stage divider
// pipeline (overflow check, then one quotient bit per stage) and the output register.
// Configuration: cfg_we with cfg_idx/cfg_wdata writes one register at the edge;
// write only while no request is in flight.
// Reset clears the pipeline valid bits and loads the identity matrix with focal
// distance 1.0; results in flight are dropped. The receiver cannot stall.
module perspective_inverse_point_map
	import pipm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] dest_x,
	input  logic signed [COORD_BITS-1:0] dest_y,
	output logic                         done,
	output logic signed [OUT_W-1:0]      src_x,
	output logic signed [OUT_W-1:0]      src_y,
	output logic                         behind_plane,
	output logic                         saturated,
	input  logic                         cfg_we,
	input  logic [IDX_W-1:0]             cfg_idx,
	input  logic [COEF_W-1:0]            cfg_wdata
);
	`include "perspective_inverse_point_map_macros.svh"

	logic signed [COEF_W-1:0] xx_q, xy_q, yx_q, yy_q, zx_q, zy_q;
	logic [FOCAL_W-1:0]       focal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_q    <= COEF_ONE;
			xy_q    <= '0;
			yx_q    <= '0;
			yy_q    <= COEF_ONE;
			zx_q    <= '0;
			zy_q    <= '0;
			focal_q <= FOCAL_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_COEF_XX: xx_q    <= cfg_wdata;
				REG_COEF_XY: xy_q    <= cfg_wdata;
				REG_COEF_YX: yx_q    <= cfg_wdata;
				REG_COEF_YY: yy_q    <= cfg_wdata;
				REG_COEF_ZX: zx_q    <= cfg_wdata;
				REG_COEF_ZY: zy_q    <= cfg_wdata;
				REG_FOCAL:   focal_q <= cfg_wdata[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1, pzx_s1, pzy_s1;
	logic signed [P_W-1:0]    px_s2, py_s2;
	logic signed [Z_W-1:0]    pz_s2;
	logic [MAG_W-1:0]         magx_s3, magy_s3;
	logic                     negx_s3, negy_s3, negx_s4, negy_s4, negx_s5, negy_s5;
	logic                     behind_s3, behind_s4, behind_s5;
	logic [D_W-1:0]           den_s3, den_s4, den_s5;
	logic [H_W+FOCAL_W-1:0]   lox_s4, loy_s4;
	logic [HI_W+FOCAL_W-1:0]  hix_s4, hiy_s4;
	logic [NUM_W-1:0]         numx_s5, numy_s5;
	logic signed [Z_W-1:0]    fz;

	assign fz = $signed({{(Z_W-FZ_W){1'b0}}, focal_q, {FOCAL_SH{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		pxx_s1 <= PROD_W'(xx_q) * PROD_W'(dest_x);
		pxy_s1 <= PROD_W'(xy_q) * PROD_W'(dest_y);
		pyx_s1 <= PROD_W'(yx_q) * PROD_W'(dest_x);
		pyy_s1 <= PROD_W'(yy_q) * PROD_W'(dest_y);
		pzx_s1 <= PROD_W'(zx_q) * PROD_W'(dest_x);
		pzy_s1 <= PROD_W'(zy_q) * PROD_W'(dest_y);

		px_s2 <= P_W'(pxx_s1) + P_W'(pxy_s1);
		py_s2 <= P_W'(pyx_s1) + P_W'(pyy_s1);
		pz_s2 <= Z_W'(pzx_s1) + Z_W'(pzy_s1) + fz;

		negx_s3   <= px_s2[P_W-1];
		negy_s3   <= py_s2[P_W-1];
		magx_s3   <= px_s2[P_W-1] ? MAG_W'(-px_s2) : MAG_W'(px_s2);
		magy_s3   <= py_s2[P_W-1] ? MAG_W'(-py_s2) : MAG_W'(py_s2);
		behind_s3 <= pz_s2[Z_W-1] || (pz_s2 == '0);
		den_s3    <= pz_s2[D_W-1:0];

		// split the wide magnitude so each product stays near 25x28
		lox_s4    <= (H_W+FOCAL_W)'(magx_s3[H_W-1:0]) * (H_W+FOCAL_W)'(focal_q);
		hix_s4    <= (HI_W+FOCAL_W)'(magx_s3[MAG_W-1:H_W]) * (HI_W+FOCAL_W)'(focal_q);
		loy_s4    <= (H_W+FOCAL_W)'(magy_s3[H_W-1:0]) * (H_W+FOCAL_W)'(focal_q);
		hiy_s4    <= (HI_W+FOCAL_W)'(magy_s3[MAG_W-1:H_W]) * (HI_W+FOCAL_W)'(focal_q);
		negx_s4   <= negx_s3;
		negy_s4   <= negy_s3;
		behind_s4 <= behind_s3;
		den_s4    <= den_s3;

		numx_s5   <= ((NUM_W'(hix_s4) << H_W) + NUM_W'(lox_s4)) << SCALE_SH;
		numy_s5   <= ((NUM_W'(hiy_s4) << H_W) + NUM_W'(loy_s4)) << SCALE_SH;
		negx_s5   <= negx_s4;
		negy_s5   <= negy_s4;
		behind_s5 <= behind_s4;
		den_s5    <= den_s4;
	end

	logic [Q_W-1:0] qx, qy;
	logic           qnx, qny, ovx, ovy;

	pipm_div_lane u_div_x (
		.clk     (clk),
		.num     (numx_s5),
		.den     (den_s5),
		.neg     (negx_s5),
		.quo     (qx),
		.quo_neg (qnx),
		.ovf     (ovx)
	);

	pipm_div_lane u_div_y (
		.clk     (clk),
		.num     (numy_s5),
		.den     (den_s5),
		.neg     (negy_s5),
		.quo     (qy),
		.quo_neg (qny),
		.ovf     (ovy)
	);

	logic vline_q [0:LANE_LAT-1];
	logic bline_q [0:LANE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_LAT; k++) begin
				vline_q[k] <= 1'b0;
			end
		end else begin
			vline_q[0] <= v_s5;
			for (int k = 1; k < LANE_LAT; k++) begin
				vline_q[k] <= vline_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		bline_q[0] <= behind_s5;
		for (int k = 1; k < LANE_LAT; k++) begin
			bline_q[k] <= bline_q[k-1];
		end
	end

	logic [OUT_W-1:0] sx_c, sy_c;
	logic             satx_c, saty_c;

	always_comb begin
		if (qnx) begin
			satx_c = ovx || (qx > SAT_NEG);
			sx_c   = satx_c ? SAT_NEG : OUT_W'(-qx);
		end else begin
			satx_c = ovx || qx[Q_W-1];
			sx_c   = satx_c ? SAT_POS : OUT_W'(qx);
		end
		if (qny) begin
			saty_c = ovy || (qy > SAT_NEG);
			sy_c   = saty_c ? SAT_NEG : OUT_W'(-qy);
		end else begin
			saty_c = ovy || qy[Q_W-1];
			sy_c   = saty_c ? SAT_POS : OUT_W'(qy);
		end
	end

	logic                    done_q;
	logic [OUT_W-1:0]        src_x_q, src_y_q;
	logic                    behind_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vline_q[LANE_LAT-1];
		end
	end

	// drop the quotient when the depth is not positive
	always_ff @(posedge clk) begin
		behind_q <= bline_q[LANE_LAT-1];
		src_x_q  <= bline_q[LANE_LAT-1] ? '0 : sx_c;
		src_y_q  <= bline_q[LANE_LAT-1] ? '0 : sy_c;
		sat_q    <= !bline_q[LANE_LAT-1] && (satx_c || saty_c);
	end

	assign done         = done_q;
	assign src_x        = src_x_q;
	assign src_y        = src_y_q;
	assign behind_plane = behind_q;
	assign saturated    = sat_q;

	`PIPM_ASSERT_IMPLY(a_flags_excl, clk, arst_n, done, !(behind_plane && saturated))
	`PIPM_ASSERT_IMPLY(a_behind_zero, clk, arst_n, done && behind_plane,
		(src_x == '0) && (src_y == '0))
	`PIPM_ASSERT_IMPLY(a_sat_bound, clk, arst_n, done && saturated,
		(src_x == SAT_POS) || (src_x == SAT_NEG) || (src_y == SAT_POS) || (src_y == SAT_NEG))
	`PIPM_ASSERT_NEXT(a_valid_adv, clk, arst_n, vline_q[LANE_LAT-1], done)
endmodule

// ===== rtl/core/pipm_div_lane.sv =====
// Pipelined restoring divider lane: 32 quotient bits, one per stage, with overflow flag.
module pipm_div_lane
	import pipm_pkg::*;
(
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [D_W-1:0]   den,
	input  logic             neg,
	output logic [Q_W-1:0]   quo,
	output logic             quo_neg,
	output logic             ovf
);
	logic [D_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0] low_s [0:Q_W];
	logic [Q_W-1:0] q_s   [0:Q_W];
	logic [D_W-1:0] den_s [0:Q_W];
	logic           neg_s [0:Q_W];
	logic           ovf_s [0:Q_W];
	logic [CMP_W-1:0] top_ext;

	assign top_ext = CMP_W'(num[NUM_W-1:Q_W]);

	// quotient of 2^32 or more is flagged here; its quotient bits are not valid
	always_ff @(posedge clk) begin
		ovf_s[0] <= top_ext >= CMP_W'(den);
		rem_s[0] <= top_ext[D_W-1:0];
		low_s[0] <= num[Q_W-1:0];
		q_s[0]   <= '0;
		den_s[0] <= den;
		neg_s[0] <= neg;
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [D_W:0] r2;
		logic [D_W:0] diff;
		logic         ge;
		assign r2   = {rem_s[k-1], low_s[k-1][Q_W-1]};
		assign diff = r2 - {1'b0, den_s[k-1]};
		assign ge   = r2 >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
			low_s[k] <= {low_s[k-1][Q_W-2:0], 1'b0};
			q_s[k]   <= {q_s[k-1][Q_W-2:0], ge};
			den_s[k] <= den_s[k-1];
			neg_s[k] <= neg_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	assign quo     = q_s[Q_W];
	assign quo_neg = neg_s[Q_W];
	assign ovf     = ovf_s[Q_W];
endmodule

// ===== sim/perspective_inverse_point_map_tb.sv =====
// Self-checking testbench for the perspective inverse point map.
module perspective_inverse_point_map_tb;
	import pipm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [OUT_W-1:0] sx;
		logic signed [OUT_W-1:0] sy;
		logic                    bh;
		logic                    st;
	} src_point_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         pin;
		src_point_t                   want;
	} dir_row_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 48;

	logic clk, arst_n;
	logic start, busy, done;
	logic signed [COORD_BITS-1:0] dest_x, dest_y;
	logic signed [OUT_W-1:0] src_x, src_y;
	logic behind_plane, saturated;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [COEF_W-1:0] cfg_wdata;

	// typed expectation travelling with the request
	logic pin_use;
	src_point_t pin_want;

	// shadow copy of the configuration
	logic signed [COEF_W-1:0] k_xx, k_xy, k_yx, k_yy, k_zx, k_zy;
	logic [FOCAL_W-1:0] k_focal;

	src_point_t pending_points[$];
	int errors, n_req, n_res, n_behind, n_sat, n_phase;
	int unsigned cycles;

	perspective_inverse_point_map DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.dest_x(dest_x), .dest_y(dest_y), .done(done),
		.src_x(src_x), .src_y(src_y), .behind_plane(behind_plane),
		.saturated(saturated), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [OUT_W-1:0] scale_lateral(longint p, longint pz,
			ref logic st);
		logic [127:0] mag, q;
		mag = 128'(p < 0 ? -p : p);
		q = (mag * (128'(k_focal) << SCALE_SH)) / 128'(pz);
		if (p < 0) begin
			if (q > 128'h8000_0000) begin
				st = 1'b1;
				return SAT_NEG;
			end
			return -q[OUT_W-1:0];
		end
		if (q > 128'h7FFF_FFFF) begin
			st = 1'b1;
			return SAT_POS;
		end
		return q[OUT_W-1:0];
	endfunction

	function automatic src_point_t map_point(logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y);
		src_point_t r;
		longint px, py, pz;
		logic st;
		px = longint'(k_xx) * longint'(x) + longint'(k_xy) * longint'(y);
		py = longint'(k_yx) * longint'(x) + longint'(k_yy) * longint'(y);
		pz = longint'(k_zx) * longint'(x) + longint'(k_zy) * longint'(y)
			+ (longint'(k_focal) << FOCAL_SH);
		st = 1'b0;
		r.sx = '0;
		r.sy = '0;
		r.bh = (pz <= 0);
		if (!r.bh) begin
			r.sx = scale_lateral(px, pz, st);
			r.sy = scale_lateral(py, pz, st);
		end
		r.st = st;
		return r;
	endfunction

	// record requests, track configuration, check results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_xx = COEF_ONE; k_xy = '0; k_yx = '0; k_yy = COEF_ONE;
			k_zx = '0; k_zy = '0; k_focal = FOCAL_RESET;
		end else begin
			if (done) begin
				n_res++;
				if (pending_points.size() == 0) begin
					errors++;
					$display("%0t: unexpected result sx=%h sy=%h", $realtime, src_x, src_y);
				end else begin
					src_point_t e;
					e = pending_points.pop_front();
					if (src_x !== e.sx || src_y !== e.sy || behind_plane !== e.bh
							|| saturated !== e.st) begin
						errors++;
						$display("%0t: mismatch expected sx=%h sy=%h bh=%b sat=%b",
							$realtime, e.sx, e.sy, e.bh, e.st);
						$display("%0t: mismatch actual   sx=%h sy=%h bh=%b sat=%b",
							$realtime, src_x, src_y, behind_plane, saturated);
					end
					if (e.bh) n_behind++;
					if (e.st) n_sat++;
				end
			end
			if (start && !busy) begin
				n_req++;
				if (pin_use) pending_points.insert(pending_points.size(), pin_want);
				else pending_points.insert(pending_points.size(), map_point(dest_x, dest_y));
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_COEF_XX: k_xx = cfg_wdata;
					REG_COEF_XY: k_xy = cfg_wdata;
					REG_COEF_YX: k_yx = cfg_wdata;
					REG_COEF_YY: k_yy = cfg_wdata;
					REG_COEF_ZX: k_zx = cfg_wdata;
					REG_COEF_ZY: k_zy = cfg_wdata;
					REG_FOCAL:   k_focal = cfg_wdata[FOCAL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[perspective_inverse_point_map] ERROR");
			$finish;
		end
	end

	// hold start high across a burst; drop it only before a gap
	task automatic send_point(logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y, logic pin, src_point_t want);
		start <= 1'b1;
		dest_x <= x;
		dest_y <= y;
		pin_use <= pin;
		pin_want <= want;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [COEF_W-1:0] v[7]);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= reg_idx_t'(i);
			cfg_wdata <= v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		n_phase++;
	endtask

	function automatic logic signed [COORD_BITS-1:0] pick_coord(int mode);
		case (mode)
			0: return COORD_BITS'($signed($urandom_range(0, 127)) - 64);
			1: return COORD_BITS'($urandom);
			default: return ($urandom_range(0, 1) == 1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
				: {1'b1, {(COORD_BITS-1){1'b0}}};
		endcase
	endfunction

	task automatic random_points(int count);
		int burst;
		int mode;
		src_point_t none;
		none = '{default: '0};
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				idle_gap();
				burst = $urandom_range(1, 24);
			end
			burst--;
			mode = $urandom_range(0, 9);
			mode = (mode < 5) ? 0 : (mode < 9) ? 1 : 2;
			send_point(pick_coord(mode), pick_coord(mode), 1'b0, none);
		end
	endtask

	function automatic logic [COEF_W-1:0] small_coef();
		return COEF_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
	endfunction

	dir_row_t dir_rows[$];
	logic [COEF_W-1:0] setting[7];

	initial begin
		src_point_t none;
		none = '{default: '0};
		errors = 0; n_req = 0; n_res = 0; n_behind = 0; n_sat = 0; n_phase = 0;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0; dest_x = '0; dest_y = '0; pin_use = 1'b0; pin_want = none;
		cfg_we = 1'b0; cfg_idx = REG_COEF_XX; cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix, focal 1.0: source equals destination in Q16.16
		dir_rows = '{
			'{16'sd0, 16'sd0, 1'b1, '{32'sh0, 32'sh0, 1'b0, 1'b0}},
			'{16'sd1, -16'sd1, 1'b1, '{32'sh0001_0000, 32'shFFFF_0000, 1'b0, 1'b0}},
			'{16'sh7FFF, 16'sh8000, 1'b1, '{32'sh7FFF_0000, 32'sh8000_0000, 1'b0, 1'b0}},
			'{16'sh8000, 16'sh7FFF, 1'b1, '{32'sh8000_0000, 32'sh7FFF_0000, 1'b0, 1'b0}},
			'{16'sh5555, 16'shAAAA, 1'b0, none},
			'{16'shAAAA, 16'sh5555, 1'b0, none}
		};
		foreach (dir_rows[i])
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].pin, dir_rows[i].want);
		settle();

		// depth zero and negative: tilt with zx = -1.0
		setting = '{COEF_ONE, 32'h0, 32'h0, COEF_ONE, 32'hC000_0000, 32'h0, 32'd256};
		write_regs(setting);
		dir_rows = '{
			'{16'sd1, 16'sd0, 1'b1, '{32'sh0, 32'sh0, 1'b1, 1'b0}},
			'{16'sd2, 16'sd5, 1'b1, '{32'sh0, 32'sh0, 1'b1, 1'b0}},
			'{-16'sd1, 16'sd0, 1'b0, none},
			'{16'sh8000, 16'sh7FFF, 1'b0, none}
		};
		foreach (dir_rows[i])
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].pin, dir_rows[i].want);
		settle();

		// coefficient extremes: saturation both ways, large focal, zero focal
		setting = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0, 32'h0, 32'd1};
		write_regs(setting);
		dir_rows = '{
			'{16'sh7FFF, 16'sd0, 1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1}},
			'{16'sh8000, 16'sh8000, 1'b0, none},
			'{16'sd1, 16'sd1, 1'b0, none}
		};
		foreach (dir_rows[i])
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].pin, dir_rows[i].want);
		random_points(100);
		settle();

		setting = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0FFF_FFFF};
		write_regs(setting);
		random_points(150);
		settle();

		setting = '{COEF_ONE, 32'h1234_5678, 32'h8765_4321, COEF_ONE,
			32'h0000_1000, 32'hFFFF_F000, 32'hF000_0000};
		write_regs(setting);
		send_point(16'sd100, -16'sd100, 1'b1, '{32'sh0, 32'sh0, 1'b0, 1'b0});
		random_points(80);
		settle();

		// mild tilts near identity, the usual operating point
		for (int p = 0; p < 4; p++) begin
			setting = '{COEF_ONE + small_coef(), small_coef(), small_coef(),
				COEF_ONE + small_coef(), small_coef() >>> 2, small_coef() >>> 2,
				COEF_W'($urandom_range(64, 1 << 20))};
			write_regs(setting);
			random_points(160);
			settle();
		end

		// fully random matrices
		for (int p = 0; p < 3; p++) begin
			setting = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				COEF_W'($urandom_range(1, 32'h0FFF_FFFF))};
			write_regs(setting);
			random_points(120);
			settle();
		end

		$display("Covered %0d requests, %0d results over %0d register settings.",
			n_req, n_res, n_phase);
		$display("Behind-plane results: %0d, saturated results: %0d.", n_behind, n_sat);
		if (errors == 0 && pending_points.size() == 0) begin
			$display("[perspective_inverse_point_map] OK");
		end else begin
			$display("[perspective_inverse_point_map] ERROR");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pipm_pkg.sv
rtl/core/pipm_div_lane.sv
rtl/core/perspective_inverse_point_map.sv
sim/perspective_inverse_point_map_tb.sv
